/* rtl/svd_pkg.sv */
// Shared widths, byte layout and stage codes for the signed varint decoder.
// Used by signed_varint_decoder and svd_checker; depends on nothing.
`default_nettype none
package svd_pkg;
	localparam int BYTE_W  = 8;
	localparam int MAG_W   = 32;
	localparam int VALUE_W = 64;
	localparam int COUNT_W = 4;
	localparam int STAGE_W = 3;

	localparam int SIGN_POS = 6;
	localparam int MORE_POS = 7;

	localparam int SH_B1 = 6;
	localparam int SH_B2 = 13;
	localparam int SH_B3 = 20;
	localparam int SH_B4 = 27;

	localparam logic [STAGE_W-1:0] STAGE_B0 = 3'd0;
	localparam logic [STAGE_W-1:0] STAGE_B1 = 3'd1;
	localparam logic [STAGE_W-1:0] STAGE_B2 = 3'd2;
	localparam logic [STAGE_W-1:0] STAGE_B3 = 3'd3;
	localparam logic [STAGE_W-1:0] STAGE_B4 = 3'd4;

	localparam logic [COUNT_W-1:0] COUNT_MIN = 4'd1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd10;
endpackage
`default_nettype wire

/* rtl/signed_varint_decoder.sv */
// Sign-magnitude varint decoder: one byte per word, 32-bit or paired 64-bit results.
// The closing byte is held in the input register, then its result word is registered.
// Throughput: one byte per cycle; a waiting result holds the input only while the
// byte in the input register closes another result.
// Reset: arst_n clears all control and decode state, narrow mode selected.
// Depends on svd_pkg.
`default_nettype none
module signed_varint_decoder (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire                                  cfg_wdata,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [svd_pkg::BYTE_W-1:0]           data_byte,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [svd_pkg::VALUE_W-1:0]   value,
	output logic [svd_pkg::COUNT_W-1:0]          bytes_used
);
	logic                          valid_s1;
	logic [svd_pkg::BYTE_W-1:0]    byte_s1;
	logic                          wide_q;
	logic [svd_pkg::MAG_W-1:0]     mag_q;
	logic [svd_pkg::STAGE_W-1:0]   stage_q;
	logic                          neg_q;
	logic [svd_pkg::MAG_W-1:0]     high_q;
	logic                          have_high_q;
	logic [svd_pkg::COUNT_W-1:0]   seen_q;
	logic                          out_valid_q;
	logic [svd_pkg::VALUE_W-1:0]   value_q;
	logic [svd_pkg::COUNT_W-1:0]   bytes_used_q;

	logic [svd_pkg::MAG_W-1:0]     mag_c;
	logic                          neg_c;
	logic                          done_c;
	logic [svd_pkg::MAG_W-1:0]     v_c;
	logic [svd_pkg::COUNT_W-1:0]   seen_c;
	logic                          emit_c;
	logic                          advance;
	logic [svd_pkg::VALUE_W-1:0]   res_c;

	always_comb begin
		mag_c  = mag_q;
		neg_c  = neg_q;
		done_c = !byte_s1[svd_pkg::MORE_POS];
		case (stage_q)
			svd_pkg::STAGE_B0: begin
				neg_c = byte_s1[svd_pkg::SIGN_POS];
				mag_c = {26'b0, byte_s1[5:0]};
			end
			svd_pkg::STAGE_B1: mag_c = mag_q | ({25'b0, byte_s1[6:0]} << svd_pkg::SH_B1);
			svd_pkg::STAGE_B2: mag_c = mag_q | ({25'b0, byte_s1[6:0]} << svd_pkg::SH_B2);
			svd_pkg::STAGE_B3: mag_c = mag_q | ({25'b0, byte_s1[6:0]} << svd_pkg::SH_B3);
			default: begin
				mag_c  = mag_q | ({24'b0, byte_s1} << svd_pkg::SH_B4);
				done_c = 1'b1;
			end
		endcase
		v_c    = neg_c ? (32'd0 - mag_c) : mag_c;
		seen_c = seen_q + 4'd1;
		emit_c = done_c && (!wide_q || have_high_q);
		res_c  = wide_q ? {high_q, v_c} : {{32{v_c[31]}}, v_c};
	end

	assign advance  = valid_s1 && (!emit_c || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			wide_q      <= 1'b0;
			mag_q       <= '0;
			stage_q     <= svd_pkg::STAGE_B0;
			neg_q       <= 1'b0;
			high_q      <= '0;
			have_high_q <= 1'b0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				seen_q <= emit_c ? '0 : seen_c;
				if (done_c) begin
					stage_q <= svd_pkg::STAGE_B0;
					mag_q   <= '0;
					neg_q   <= 1'b0;
					if (wide_q) begin
						if (!have_high_q) begin
							high_q      <= v_c;
							have_high_q <= 1'b1;
						end else begin
							high_q      <= '0;
							have_high_q <= 1'b0;
						end
					end
				end else begin
					stage_q <= stage_q + 3'd1;
					mag_q   <= mag_c;
					neg_q   <= neg_c;
				end
			end
			if (advance && emit_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				wide_q      <= cfg_wdata;
				have_high_q <= 1'b0;
				high_q      <= '0;
				seen_q      <= {1'b0, stage_q};
			end
		end
	end

	// hold payload, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
		if (advance && emit_c) begin
			value_q      <= res_c;
			bytes_used_q <= seen_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign bytes_used = bytes_used_q;
endmodule
`default_nettype wire

/* rtl/svd_checker.sv */
// Port-level assertions for signed_varint_decoder, bound into every decoder instance.
// Depends on svd_pkg.
`default_nettype none
module svd_checker (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  cfg_we,
	input wire                                  cfg_wdata,
	input wire                                  in_valid,
	input wire                                  in_ready,
	input wire  [svd_pkg::BYTE_W-1:0]           data_byte,
	input wire                                  out_valid,
	input wire                                  out_ready,
	input wire  signed [svd_pkg::VALUE_W-1:0]   value,
	input wire  [svd_pkg::COUNT_W-1:0]          bytes_used
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(bytes_used))
		else $error("result word dropped or changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bytes_used >= svd_pkg::COUNT_MIN && bytes_used <= svd_pkg::COUNT_MAX)
		else $error("bytes_used out of range");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result word valid on leaving reset");
endmodule

bind signed_varint_decoder svd_checker u_svd_checker (.*);
`default_nettype wire

/* test/svd_checker.sv */
`timescale 1ns / 1ps
// Checker for the signed varint decoder: watches both channels and the width register,
// predicts each decoded word from the accepted bytes and compares it on the output.
// Depends on svd_pkg.
module svd_tb_checker (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire                                   cfg_wdata,
	input  wire                                   in_valid,
	input  wire                                   in_ready,
	input  wire [svd_pkg::BYTE_W-1:0]             data_byte,
	input  wire                                   out_valid,
	input  wire                                   out_ready,
	input  wire [svd_pkg::VALUE_W-1:0]            value,
	input  wire [svd_pkg::COUNT_W-1:0]            bytes_used,
	output int                                    errors,
	output int                                    pending
);
	typedef struct packed {
		logic [svd_pkg::VALUE_W-1:0] value;
		logic [svd_pkg::COUNT_W-1:0] count;
	} decoded_t;

	decoded_t due_values[$];

	logic                          wide;
	logic [svd_pkg::MAG_W-1:0]     mag_acc;
	logic [svd_pkg::STAGE_W-1:0]   stage;
	logic                          negative;
	logic [svd_pkg::MAG_W-1:0]     upper_half;
	logic                          upper_held;
	logic [svd_pkg::COUNT_W-1:0]   consumed;

	task automatic clear_state();
		wide = 1'b0;
		mag_acc = '0;
		stage = svd_pkg::STAGE_B0;
		negative = 1'b0;
		upper_half = '0;
		upper_held = 1'b0;
		consumed = '0;
		errors = 0;
		due_values.delete();
	endtask

	// drop a waiting high half and its bytes; a value in progress carries on
	task automatic select_width(input logic w);
		wide = w;
		upper_held = 1'b0;
		upper_half = '0;
		consumed = {1'b0, stage};
	endtask

	task automatic decode_byte(input logic [svd_pkg::BYTE_W-1:0] b);
		logic                        closing;
		logic [svd_pkg::MAG_W-1:0]   word;
		logic [svd_pkg::MAG_W-1:0]   low6;
		logic [svd_pkg::MAG_W-1:0]   low7;
		logic [svd_pkg::MAG_W-1:0]   full8;
		decoded_t                    r;
		low6 = '0;
		low7 = '0;
		full8 = '0;
		low6[svd_pkg::SIGN_POS-1:0] = b[svd_pkg::SIGN_POS-1:0];
		low7[svd_pkg::MORE_POS-1:0] = b[svd_pkg::MORE_POS-1:0];
		full8[svd_pkg::BYTE_W-1:0] = b;
		consumed = consumed + 1'b1;
		closing = !b[svd_pkg::MORE_POS];
		case (stage)
		svd_pkg::STAGE_B0: begin
			negative = b[svd_pkg::SIGN_POS];
			mag_acc = low6;
		end
		svd_pkg::STAGE_B1: mag_acc = mag_acc | (low7 << svd_pkg::SH_B1);
		svd_pkg::STAGE_B2: mag_acc = mag_acc | (low7 << svd_pkg::SH_B2);
		svd_pkg::STAGE_B3: mag_acc = mag_acc | (low7 << svd_pkg::SH_B3);
		default: begin
			mag_acc = mag_acc | (full8 << svd_pkg::SH_B4);
			closing = 1'b1;
		end
		endcase
		if (!closing) begin
			stage = stage + 1'b1;
			return;
		end
		stage = svd_pkg::STAGE_B0;
		word = negative ? -mag_acc : mag_acc;
		mag_acc = '0;
		negative = 1'b0;
		if (wide) begin
			if (!upper_held) begin
				upper_half = word;
				upper_held = 1'b1;
				return;
			end
			r.value = {upper_half, word};
			upper_held = 1'b0;
			upper_half = '0;
		end else begin
			r.value = {{svd_pkg::MAG_W{word[svd_pkg::MAG_W-1]}}, word};
		end
		r.count = consumed;
		consumed = '0;
		due_values.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			clear_state();
		end else begin
			if (out_valid && out_ready) begin
				if (due_values.size() == 0) begin
					$display("%0t: unexpected word: value %h bytes_used %0d",
						$time, value, bytes_used);
					errors = errors + 1;
				end else begin
					want = due_values.pop_front();
					if (value !== want.value) begin
						$display("%0t: value expected %h actual %h",
							$time, want.value, value);
						errors = errors + 1;
					end
					if (bytes_used !== want.count) begin
						$display("%0t: bytes_used expected %0d actual %0d",
							$time, want.count, bytes_used);
						errors = errors + 1;
					end
				end
			end
			if (cfg_we)
				select_width(cfg_wdata);
			if (in_valid && in_ready)
				decode_byte(data_byte);
		end
		pending = due_values.size();
	end
endmodule

/* test/signed_varint_decoder_tb.sv */
`timescale 1ns / 1ps
// Testbench top for signed_varint_decoder: drives encoded byte streams and width
// settings under varied idling and gives the verdict. Depends on svd_pkg and svd_tb_checker.
module signed_varint_decoder_tb;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_BYTES  = 60;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic                              cfg_wdata;
	logic                              in_valid;
	logic [svd_pkg::BYTE_W-1:0]        data_byte;
	logic                              out_ready = 1'b0;
	wire                               in_ready;
	wire                               out_valid;
	wire [svd_pkg::VALUE_W-1:0]        value;
	wire [svd_pkg::COUNT_W-1:0]        bytes_used;

	int   errors;
	int   pending;
	int   send_idle;
	int   recv_stall;
	int   bytes_sent;
	int   results_seen = 0;
	int   width_writes;
	int   quiet = 0;
	logic in_fire = 1'b0;

	signed_varint_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.bytes_used (bytes_used)
	);

	svd_tb_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.bytes_used (bytes_used),
		.errors     (errors),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (out_valid && out_ready)
			results_seen <= results_seen + 1;
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic push_byte(input logic [svd_pkg::BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(negedge clk); while (!in_fire);
		bytes_sent++;
	endtask

	task automatic send_number(input logic neg, input logic [svd_pkg::MAG_W-1:0] mag,
		input int len);
		push_byte({len > 1, neg, mag[svd_pkg::SIGN_POS-1:0]});
		for (int k = 1; k < len && k < 4; k++)
			push_byte({k < len - 1, 7'(mag >> (svd_pkg::SH_B1 + 7 * (k - 1)))});
		if (len >= 5)
			push_byte({3'($urandom), mag[svd_pkg::MAG_W-1:svd_pkg::SH_B4]});
	endtask

	// hold the sender until every due word is out and the pipeline has settled
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_width(input logic w);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
		width_writes++;
	endtask

	task automatic random_traffic(input int count);
		int                          stop;
		logic [svd_pkg::MAG_W-1:0]   mag;
		stop = bytes_sent + count;
		while (bytes_sent < stop) begin
			if ($urandom_range(99) < 12) begin
				push_byte(8'($urandom));
			end else begin
				case ($urandom_range(9))
				0: mag = '0;
				1: mag = '1;
				2: mag = 32'h8000_0000;
				default: mag = $urandom;
				endcase
				send_number(1'($urandom_range(1)), mag, $urandom_range(1, 5));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		send_idle = 0;
		recv_stall = 0;
		bytes_sent = 0;
		width_writes = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_width(1'b0);
		send_number(1'b0, '0, 1);
		send_number(1'b0, '1, 1);
		send_number(1'b1, '1, 1);
		send_number(1'b1, '0, 1);
		send_number(1'b0, '1, 5);
		send_number(1'b1, 32'h8000_0000, 5);

		write_width(1'b1);
		send_number(1'b1, '1, 5);
		send_number(1'b0, 32'h8000_0000, 5);
		send_number(1'b0, 32'd1, 1);
		push_byte(8'h85);
		write_width(1'b1);
		push_byte(8'h01);
		send_number(1'b1, 32'd5, 1);

		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin send_idle = 0;  recv_stall = 0;  end
			1: begin send_idle = 63; recv_stall = 0;  end
			2: begin send_idle = 0;  recv_stall = 63; end
			default: begin send_idle = 9; recv_stall = 9; end
			endcase
			write_width(p[0]);
			random_traffic(PHASE_BYTES);
			write_width(1'($urandom_range(1)));
			random_traffic(PHASE_BYTES);
		end

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("sent %0d bytes, checked %0d words across %0d width writes",
			bytes_sent, results_seen, width_writes);
		$display("narrow and wide decoding under free-flowing, sender, receiver and mixed idling");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
